FILE: hdl/date_month_dictionary_codec_core_macros.svh
// Assertion macros shared by the checker of the date dictionary codec.
`ifndef DATE_MONTH_DICTIONARY_CODEC_CORE_MACROS_SVH
`define DATE_MONTH_DICTIONARY_CODEC_CORE_MACROS_SVH

// Checked only while the block is out of reset.
`define DMDC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define DMDC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hdl/dmdc_pkg.sv
// Types and constants of the date dictionary codec.
package dmdc_pkg;

  localparam int unsigned DAY_BITS   = 5;
  localparam logic [31:0] DAY_MASK   = 32'o37;
  localparam int unsigned CODE_W     = 13;
  localparam int unsigned SLOT_W     = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_DECODE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_MASK  = 1'd1;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] date_value;
    logic [SLOT_W-1:0]  entry_index;
    logic [CODE_W-1:0]  code_in;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic [CODE_W-1:0]  code_out;
    logic signed [31:0] decoded_date;
    logic [SLOT_W-1:0]  found_index;
    logic [31:0]        hit_frequency;
    logic signed [63:0] running_checksum;
  } out_item_t;

endpackage

FILE: hdl/date_month_dictionary_codec_core.sv
// Date dictionary codec: sorted year-month table, binary-search encode, table decode.
//
// After reset the block clears every hit counter in S_CLEAR and
// holds in_stall_o high meanwhile; configuration writes are taken at any time.
// It then works on one item at a time. A load or an unused op goes from
// acceptance straight to S_OUT, a decode through S_DEC first. An encode
// issues its first probe read on acceptance, reads one probe in each S_PROBE
// step of the binary search, then checks the final entry and updates its
// counter in S_CHECK, and posts the result from S_OUT. The input is free again
// in the cycle in which the result appears at the output. The probe rate is set by the
// single read port of the month table, whose read data is registered. A
// finished item waits in the output register, so the next item can be
// accepted while it is stalled; the result of that next item then waits until
// the output register is free.
module date_month_dictionary_codec_core #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dmdc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dmdc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  dmdc_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output dmdc_pkg::out_item_t                 out_data_o
);
  import dmdc_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_PROBE = 6'b000100,
    S_CHECK = 6'b001000,
    S_DEC   = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [8:0] entry_count_q;
  logic [7:0] index_mask_q;
  logic [63:0] enc_sum_q, enc_sum_d, dec_sum_q, dec_sum_d;
  logic out_valid_q, out_valid_d;
  out_item_t out_data_q, out_data_d, res_q, res_d;

  logic [CW-1:0] f_q, f_d, l_q, l_d, m_q, m_d, count_q, count_d;
  logic [31:0] ym_q, ym_d;
  logic [DAY_BITS-1:0] day_q, day_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic idx_ok_q, idx_ok_d;

  // Month table and hit counters, one write and one registered read port each.
  logic [31:0] month_mem [TABLE_DEPTH];
  logic [31:0] freq_mem [TABLE_DEPTH];
  logic mt_we, fq_we;
  logic [AW-1:0] mt_waddr, mt_raddr, fq_waddr, fq_raddr;
  logic [31:0] mt_wdata, fq_wdata, mt_rdata_q, fq_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mt_we) begin
      month_mem[mt_waddr] <= mt_wdata;
    end
    mt_rdata_q <= month_mem[mt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (fq_we) begin
      freq_mem[fq_waddr] <= fq_wdata;
    end
    fq_rdata_q <= freq_mem[fq_raddr];
  end

  // Decoded views of the incoming item.
  logic [31:0] slot32, idx32, ec32;
  logic slot_ok;
  logic [SLOT_W-1:0] idx_in;
  logic [CW-1:0] count_now;
  logic [31:0] ym_in;

  assign slot32    = 32'(in_data_i.entry_index);
  assign slot_ok   = slot32 < TABLE_DEPTH;
  assign idx_in    = in_data_i.code_in[CODE_W-1:DAY_BITS] & index_mask_q;
  assign idx32     = 32'(idx_in);
  assign ec32      = 32'(entry_count_q);
  assign count_now = (ec32 > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(entry_count_q);
  assign ym_in     = in_data_i.date_value & ~DAY_MASK;

  // One search step: narrow the interval with the probe just read, then form
  // the next midpoint so its read is issued in the same cycle.
  logic [CW-1:0] srch_f, srch_l, mid;
  logic go_on, less;

  assign less = $signed(mt_rdata_q) < $signed(ym_q);

  always_comb begin
    if (state_q == S_PROBE) begin
      srch_f = less ? (m_q + CW'(1)) : f_q;
      srch_l = less ? l_q : m_q;
    end else begin
      srch_f = '0;
      srch_l = count_now;
    end
  end

  assign mid   = srch_f + ((srch_l - srch_f) >> 1);
  assign go_on = srch_l > srch_f;

  assign mt_raddr = (state_q == S_IDLE && in_data_i.op == OP_DECODE) ? idx32[AW-1:0]
                  : (go_on ? mid[AW-1:0] : srch_f[AW-1:0]);
  assign fq_raddr = srch_f[AW-1:0];

  // Final check of an encode.
  logic [31:0] f32, freq_new, entry;
  logic enc_hit;
  logic [SLOT_W-1:0] j8;

  assign f32      = 32'(f_q);
  assign j8       = f32[SLOT_W-1:0];
  assign enc_hit  = (f_q < count_q) && (mt_rdata_q == ym_q);
  assign freq_new = (fq_rdata_q == '1) ? fq_rdata_q : fq_rdata_q + 32'd1;
  assign entry    = idx_ok_q ? mt_rdata_q : '0;

  assign in_stall_o = state_q != S_IDLE;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    enc_sum_d   = enc_sum_q;
    dec_sum_d   = dec_sum_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    res_d       = res_q;
    f_d         = f_q;
    l_d         = l_q;
    m_d         = m_q;
    count_d     = count_q;
    ym_d        = ym_q;
    day_d       = day_q;
    idx_d       = idx_q;
    idx_ok_d    = idx_ok_q;
    mt_we       = 1'b0;
    mt_waddr    = slot32[AW-1:0];
    mt_wdata    = in_data_i.date_value;
    fq_we       = 1'b0;
    fq_waddr    = clr_q;
    fq_wdata    = '0;

    case (state_q)
      S_CLEAR: begin
        fq_we = 1'b1;
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(TABLE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          res_d    = '0;
          ym_d     = ym_in;
          // A decode takes its day from the code, an encode from the date.
          day_d    = (in_data_i.op == OP_DECODE) ? in_data_i.code_in[DAY_BITS-1:0]
                                                 : in_data_i.date_value[DAY_BITS-1:0];
          count_d  = count_now;
          idx_d    = idx_in;
          idx_ok_d = idx32 < TABLE_DEPTH;
          f_d      = srch_f;
          l_d      = srch_l;
          m_d      = mid;
          case (in_data_i.op)
            OP_LOAD: begin
              mt_we   = slot_ok;
              state_d = S_OUT;
            end
            OP_ENCODE: begin
              state_d = go_on ? S_PROBE : S_CHECK;
            end
            OP_DECODE: begin
              state_d = S_DEC;
            end
            default: begin
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_PROBE: begin
        f_d = srch_f;
        l_d = srch_l;
        m_d = mid;
        if (!go_on) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (enc_hit) begin
          fq_we    = 1'b1;
          fq_waddr = f_q[AW-1:0];
          fq_wdata = freq_new;
          enc_sum_d = enc_sum_q + {{32{ym_q[31]}}, ym_q};
          res_d.hit           = 1'b1;
          res_d.code_out      = {j8 & index_mask_q, day_q};
          res_d.found_index   = j8;
          res_d.hit_frequency = freq_new;
        end
        res_d.running_checksum = enc_sum_d;
        state_d = S_OUT;
      end
      S_DEC: begin
        dec_sum_d = dec_sum_q + {{32{entry[31]}}, entry};
        res_d.decoded_date     = entry | {{(32 - DAY_BITS){1'b0}}, day_q};
        res_d.found_index      = idx_q;
        res_d.running_checksum = dec_sum_d;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      clr_q         <= '0;
      enc_sum_q     <= '0;
      dec_sum_q     <= '0;
      out_valid_q   <= 1'b0;
      entry_count_q <= '0;
      index_mask_q  <= 8'hFF;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      enc_sum_q   <= enc_sum_d;
      dec_sum_q   <= dec_sum_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ENTRY_COUNT: entry_count_q <= cfg_data_i[8:0];
          CFG_INDEX_MASK:  index_mask_q  <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    res_q      <= res_d;
    f_q        <= f_d;
    l_q        <= l_d;
    m_q        <= m_d;
    count_q    <= count_d;
    ym_q       <= ym_d;
    day_q      <= day_d;
    idx_q      <= idx_d;
    idx_ok_q   <= idx_ok_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: hdl/dmdc_checker.sv
// Port-level checker for the date dictionary codec, bound to the top level.
`include "date_month_dictionary_codec_core_macros.svh"

module dmdc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input dmdc_pkg::out_item_t out_data_o
);
  import dmdc_pkg::*;

  logic hit_clean;

  assign hit_clean = (out_data_o.decoded_date == 0) && (out_data_o.hit_frequency != 0);

  // A result that is stalled stays offered.
  `DMDC_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped")

  // Reset empties the output and starts the counter clearing pass.
  `DMDC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o, "result offered in reset")
  `DMDC_ASSERT_ALWAYS(a_reset_busy, !rst_ni |=> in_stall_o, "item taken after reset")

  // One item at a time: an accepted item keeps the input side busy.
  `DMDC_ASSERT(a_one_item, in_valid_i && !in_stall_o |=> in_stall_o, "second item taken")

  // An encode hit carries no decoded date and a counter that has counted it.
  `DMDC_ASSERT(a_hit_fields, out_valid_o && out_data_o.hit |-> hit_clean, "bad hit result")

endmodule

bind date_month_dictionary_codec_core dmdc_checker u_dmdc_checker (.*);

FILE: sim/date_month_dictionary_codec_core_test.sv
// Self-checking testbench of the date dictionary codec with a predictor and a result scoreboard.
module date_month_dictionary_codec_core_test;
  import dmdc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned DEPTH = 256;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned N_PHASES = 9;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e              kind;
    in_item_t               item;
    logic [CFG_IDX_W-1:0]   reg_index;
    logic [CFG_DATA_W-1:0]  reg_value;
    bit                     typed;
    out_item_t              result;
  } stim_row_t;

  // Register settings of the random phases: entry count and index mask.
  int unsigned phase_count [N_PHASES] = '{256, 0, 1, 17, 300, 511, 128, 256, 200};
  int unsigned phase_mask  [N_PHASES] = '{255, 255, 1, 15, 127, 255, 63, 1, 7};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;

  // Predictor state and its copy of the registers.
  logic [31:0] month_tbl [DEPTH];
  logic [31:0] hit_cnt [DEPTH];
  logic [63:0] encode_sum = '0;
  logic [63:0] decode_sum = '0;
  logic [8:0]  cfg_entry_count = '0;
  logic [7:0]  cfg_index_mask = 8'd255;

  out_item_t   pending_results [$];
  int unsigned idle_pct = 19;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_loads = 0, n_hits = 0, n_misses = 0, n_decodes = 0, n_unused = 0;
  int unsigned reg_writes = 0;

  date_month_dictionary_codec_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    foreach (hit_cnt[i]) begin
      hit_cnt[i] = '0;
      month_tbl[i] = '0;
    end
  end

  function automatic out_item_t predict_codec(input in_item_t it);
    out_item_t   r;
    logic [31:0] ym, entry, idx_bits;
    int unsigned lim, lo, hi, mid, idx;
    r = '0;
    case (it.op)
      OP_LOAD: month_tbl[it.entry_index] = it.date_value;
      OP_ENCODE: begin
        lim = (cfg_entry_count > DEPTH) ? DEPTH : cfg_entry_count;
        ym = it.date_value & ~DAY_MASK;
        lo = 0;
        hi = lim;
        // Lower-bound search with signed comparisons.
        while (hi > lo) begin
          mid = lo + (hi - lo) / 2;
          if ($signed(month_tbl[mid]) < $signed(ym)) lo = mid + 1;
          else hi = mid;
        end
        if (lo < lim && month_tbl[lo] == ym) begin
          if (hit_cnt[lo] != 32'hFFFF_FFFF) hit_cnt[lo] = hit_cnt[lo] + 1;
          encode_sum = encode_sum + {{32{ym[31]}}, ym};
          idx_bits = 32'(lo[7:0] & cfg_index_mask);
          r.hit = 1'b1;
          r.code_out = 13'((idx_bits << DAY_BITS) | (it.date_value & DAY_MASK));
          r.found_index = lo[7:0];
          r.hit_frequency = hit_cnt[lo];
        end
        r.running_checksum = encode_sum;
      end
      OP_DECODE: begin
        idx = it.code_in[CODE_W-1:DAY_BITS] & cfg_index_mask;
        entry = month_tbl[idx];
        decode_sum = decode_sum + {{32{entry[31]}}, entry};
        r.decoded_date = entry | (32'(it.code_in) & DAY_MASK);
        r.found_index = idx[7:0];
        r.running_checksum = decode_sum;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Offers one item, with random idle cycles ahead of it, and books its expected result.
  task automatic send_item(input in_item_t it, input bit use_typed, input out_item_t typed_res);
    out_item_t predicted;
    while ($urandom_range(99, 0) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do begin
      @(posedge clk);
    end while (in_stall);
    predicted = predict_codec(it);
    pending_results.push_back(use_typed ? typed_res : predicted);
    case (it.op)
      OP_LOAD: n_loads++;
      OP_ENCODE: if (predicted.hit) n_hits++; else n_misses++;
      OP_DECODE: n_decodes++;
      default: n_unused++;
    endcase
  endtask

  // Registers are written only once every pending result has come back.
  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_ENTRY_COUNT) cfg_entry_count = val;
    else cfg_index_mask = val[7:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  function automatic stim_row_t item_row(input logic [1:0] op, input logic [31:0] date,
                                         input logic [7:0] slot, input logic [12:0] code,
                                         input bit zero_result);
    stim_row_t r;
    r.kind = ROW_ITEM;
    r.item.op = op;
    r.item.date_value = date;
    r.item.entry_index = slot;
    r.item.code_in = code;
    r.reg_index = '0;
    r.reg_value = '0;
    r.typed = zero_result;
    r.result = '0;
    return r;
  endfunction

  function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    stim_row_t r;
    r = item_row(OP_LOAD, '0, '0, '0, 1'b0);
    r.kind = ROW_REG;
    r.reg_index = idx;
    r.reg_value = val;
    return r;
  endfunction

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99, 0) < idle_pct);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result arrived with nothing pending");
      end else begin
        want = pending_results.pop_front();
        if (out_data.hit !== want.hit)
          report_mismatch($sformatf("hit %0b, want %0b", out_data.hit, want.hit));
        if (out_data.code_out !== want.code_out)
          report_mismatch($sformatf("code_out %h, want %h", out_data.code_out, want.code_out));
        if (out_data.decoded_date !== want.decoded_date)
          report_mismatch($sformatf("decoded_date %h, want %h",
                                    out_data.decoded_date, want.decoded_date));
        if (out_data.found_index !== want.found_index)
          report_mismatch($sformatf("found_index %0d, want %0d",
                                    out_data.found_index, want.found_index));
        if (out_data.hit_frequency !== want.hit_frequency)
          report_mismatch($sformatf("hit_frequency %0d, want %0d",
                                    out_data.hit_frequency, want.hit_frequency));
        if (out_data.running_checksum !== want.running_checksum)
          report_mismatch($sformatf("running_checksum %h, want %h",
                                    out_data.running_checksum, want.running_checksum));
      end
    end
  end

  // Watchdog: ends the run when neither side moves an item for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: %0d cycles without progress, %0d results pending",
               quiet_cycles, pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    stim_row_t   directed_rows [$];
    in_item_t    it;
    longint      month_acc;
    int unsigned lim, j, pick;

    // Count of zero makes every encode a miss; loads and the unused op give zero results.
    directed_rows.push_back(item_row(OP_ENCODE, 32'h1234_5678, 8'hFF, 13'h1FFF, 1'b1));
    directed_rows.push_back(item_row(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF, 13'h1FFF, 1'b1));
    directed_rows.push_back(item_row(OP_LOAD, 32'h8000_0000, 8'd0, 13'h0AAA, 1'b1));
    directed_rows.push_back(item_row(OP_LOAD, 32'hFFFF_FFE0, 8'd1, 13'h1555, 1'b1));
    directed_rows.push_back(item_row(OP_LOAD, 32'h0000_0000, 8'd2, 13'h0000, 1'b1));
    directed_rows.push_back(item_row(OP_LOAD, 32'h7FFF_FFE0, 8'd3, 13'h1FFF, 1'b1));
    // An entry with day bits set can be decoded but never hit.
    directed_rows.push_back(item_row(OP_LOAD, 32'h7FFF_FFFF, 8'd4, 13'h0123, 1'b1));
    directed_rows.push_back(reg_row(CFG_ENTRY_COUNT, 9'd5));
    directed_rows.push_back(item_row(OP_ENCODE, 32'h8000_001F, 8'h00, 13'h1FFF, 1'b0));
    directed_rows.push_back(item_row(OP_ENCODE, 32'h8000_0000, 8'hFF, 13'h0000, 1'b0));
    directed_rows.push_back(item_row(OP_ENCODE, 32'hFFFF_FFFF, 8'h5A, 13'h0F0F, 1'b0));
    directed_rows.push_back(item_row(OP_ENCODE, 32'h0000_001F, 8'hA5, 13'h10F0, 1'b0));
    directed_rows.push_back(item_row(OP_ENCODE, 32'h7FFF_FFFF, 8'h3C, 13'h0333, 1'b0));
    directed_rows.push_back(item_row(OP_ENCODE, 32'h0000_0020, 8'h00, 13'h0000, 1'b0));
    directed_rows.push_back(item_row(OP_ENCODE, 32'hFFFF_FFC0, 8'hFF, 13'h1FFF, 1'b0));
    directed_rows.push_back(item_row(OP_DECODE, 32'hFFFF_FFFF, 8'hFF, 13'h0000, 1'b0));
    directed_rows.push_back(item_row(OP_DECODE, 32'h0000_0000, 8'h00, 13'h009F, 1'b0));
    directed_rows.push_back(reg_row(CFG_INDEX_MASK, 9'd3));
    directed_rows.push_back(item_row(OP_DECODE, 32'h5555_5555, 8'h55, 13'h1FFF, 1'b0));
    directed_rows.push_back(item_row(OP_ENCODE, 32'h7FFF_FFE5, 8'hAA, 13'h0AAA, 1'b0));
    directed_rows.push_back(reg_row(CFG_INDEX_MASK, 9'd1));
    directed_rows.push_back(item_row(OP_ENCODE, 32'hFFFF_FFE0, 8'h01, 13'h0001, 1'b0));
    directed_rows.push_back(item_row(OP_ENCODE, 32'h0000_0000, 8'h80, 13'h1000, 1'b0));
    directed_rows.push_back(item_row(OP_DECODE, 32'hAAAA_AAAA, 8'h7F, 13'h1FFF, 1'b0));
    directed_rows.push_back(reg_row(CFG_ENTRY_COUNT, 9'd1));
    directed_rows.push_back(item_row(OP_ENCODE, 32'h7FFF_FFE0, 8'hFE, 13'h1FFE, 1'b0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG)
        program_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
      else
        send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
    end

    // Fill every slot with ascending year-month values spread over the signed range.
    month_acc = -64'sd2147483648;
    for (int s = 0; s < DEPTH; s++) begin
      it.op = OP_LOAD;
      it.entry_index = s[7:0];
      it.code_in = 13'($urandom);
      it.date_value = month_acc[31:0];
      if ($urandom_range(15, 0) == 0) it.date_value[4:0] = 5'($urandom);
      send_item(it, 1'b0, '0);
      month_acc += 32 * longint'($urandom_range(786431, 1));
      if (month_acc > 64'sd2147483616) month_acc = 64'sd2147483616;
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      program_reg(CFG_ENTRY_COUNT, 9'(phase_count[ph]));
      program_reg(CFG_INDEX_MASK, 9'(phase_mask[ph]));
      idle_pct = (ph == 3) ? 0 : 19;
      lim = (phase_count[ph] > DEPTH) ? DEPTH : phase_count[ph];
      repeat (48) begin
        it.date_value = $urandom;
        it.entry_index = 8'($urandom);
        it.code_in = 13'($urandom);
        pick = $urandom_range(99, 0);
        if (pick < 65) begin
          it.op = OP_ENCODE;
          // Most encodes reuse a stored year-month so that they hit.
          if (lim != 0 && $urandom_range(3, 0) != 0) begin
            j = $urandom_range(lim - 1, 0);
            it.date_value = (month_tbl[j] & ~DAY_MASK) | (it.date_value & DAY_MASK);
          end
        end else if (pick < 88) begin
          it.op = OP_DECODE;
        end else if (pick < 95) begin
          it.op = OP_LOAD;
          // Mostly reload the same value; the rest scrambles the table order.
          if ($urandom_range(3, 0) != 0) it.date_value = month_tbl[it.entry_index];
        end else begin
          it.op = OP_UNUSED;
        end
        send_item(it, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Items: %0d loads, %0d encode hits, %0d encode misses, %0d decodes, %0d unused",
             n_loads, n_hits, n_misses, n_decodes, n_unused);
    $display("Register writes: %0d, entry counts from 0 to 511, index masks from 1 to 255",
             reg_writes);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
